[rtl/asrt_pkg.sv]
// ----------------------------------------------------------------------------
// asrt_pkg: shared types and constants for the two-ring audio transfer block
// Codes, field widths, configuration bundle and result record.
// ----------------------------------------------------------------------------
package asrt_pkg;

   localparam int HeaderBytesDef = 40;
   localparam int UnitBytesDef   = 1024;
   localparam int ClearBytesDef  = 4096;

   localparam logic [20:0] HostMin = 21'd1024;
   localparam logic [20:0] PlayMin = 21'd2048;
   localparam logic [20:0] RingMax = 21'd1048576;
   localparam logic [20:0] PendMax = 21'h1FFFFF;

   localparam int DvdW = 32;   // dividend width of the remainder unit
   localparam int DivW = 21;   // divisor width
   localparam int RemW = 20;   // remainder width (divisor <= 2^20)

   localparam logic [2:0] CmdQuery  = 3'd0;
   localparam logic [2:0] CmdCommit = 3'd1;
   localparam logic [2:0] CmdSend   = 3'd2;
   localparam logic [2:0] CmdPause  = 3'd3;
   localparam logic [2:0] CmdResume = 3'd4;
   localparam logic [2:0] CmdReset  = 3'd5;

   localparam logic [2:0] KindAck   = 3'd0;
   localparam logic [2:0] KindCopy  = 3'd1;
   localparam logic [2:0] KindFree  = 3'd2;
   localparam logic [2:0] KindStart = 3'd3;
   localparam logic [2:0] KindStop  = 3'd4;

   localparam logic [1:0] ModeHeader = 2'd0;
   localparam logic [1:0] ModePreset = 2'd1;
   localparam logic [1:0] ModePlay   = 2'd2;
   localparam logic [1:0] ModePaused = 2'd3;

   localparam logic [1:0] RegHost = 2'd0;
   localparam logic [1:0] RegPlay = 2'd1;
   localparam logic [1:0] RegBase = 2'd2;

   typedef struct packed {
      logic [20:0] host_ring_bytes;
      logic [20:0] play_ring_bytes;
      logic [23:0] play_ring_base;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [19:0] dest_offset;
      logic [19:0] source_offset;
      logic [20:0] length;
      logic [19:0] second_offset;
      logic [20:0] second_length;
      logic        into_header;
   } res_type;

endpackage

[rtl/audio_stream_two_ring_transfer.sv]
// ----------------------------------------------------------------------------
// audio_stream_two_ring_transfer: pointer keeper for a two-ring audio stream
// Sequencer over a shared remainder unit that answers ring commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command transaction (command, byte_count,
//   raw_play_address). rsp_* returns one to three result transactions per
//   command; rsp_last marks the final one. The APB port sets the host ring
//   size, the playback ring size and the playback base (addresses 0, 4, 8).
// Sequencing:
//   Every command first reduces write_pos and play_write_pos through the
//   shared 32-step remainder unit. Send in preset mode runs it a third
//   time, commit as well. req_ready is high only while the sequencer is
//   idle; one command is in work at a time.
// Reset:
//   Synchronous, active high: header mode, all pointers and totals zero,
//   registers at their reset sizes. No clearing pass is needed.
// Stall:
//   Results sit in one output register; while rsp_ready is low the
//   sequencer holds the next result. The next command is taken while the
//   last result of the previous one still waits.
// ----------------------------------------------------------------------------
module audio_stream_two_ring_transfer #(
   parameter int HEADER_BYTES = asrt_pkg::HeaderBytesDef,
   parameter int UNIT_BYTES   = asrt_pkg::UnitBytesDef,   // power of two
   parameter int CLEAR_BYTES  = asrt_pkg::ClearBytesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [20:0] req_byte_count,
   input  logic [23:0] req_raw_play_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [19:0] rsp_dest_offset,
   output logic [19:0] rsp_source_offset,
   output logic [20:0] rsp_length,
   output logic [19:0] rsp_second_offset,
   output logic [20:0] rsp_second_length,
   output logic        rsp_into_header,
   output logic [20:0] rsp_sent_bytes,
   output logic        rsp_preset_done,
   output logic [1:0]  rsp_mode_now,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [20:0] UnitMask = ~21'(UNIT_BYTES - 1);
   localparam logic [21:0] Unit22   = 22'(UNIT_BYTES);
   localparam logic [5:0]  HdrBytes = 6'(HEADER_BYTES);

   typedef enum logic [17:0] {
      ST_IDLE       = 18'h00001,
      ST_CLAMP      = 18'h00002,
      ST_MOD_PUT    = 18'h00004,
      ST_MOD_LAST   = 18'h00008,
      ST_DISPATCH   = 18'h00010,
      ST_COMMIT     = 18'h00020,
      ST_COMMIT_ADD = 18'h00040,
      ST_COMMIT_MOD = 18'h00080,
      ST_MOD_SENT   = 18'h00100,
      ST_POS        = 18'h00200,
      ST_FREE       = 18'h00400,
      ST_REDUCE     = 18'h00800,
      ST_SPLIT      = 18'h01000,
      ST_SRC_A      = 18'h02000,
      ST_SRC_B      = 18'h04000,
      ST_SRC_C      = 18'h08000,
      ST_TRIM       = 18'h10000,
      ST_SEGS       = 18'h20000
   } state_type;

   // emit shares the idle code space poorly, so it has a bit of its own
   logic emit_ff, emit_in;

   asrt_pkg::cfg_type cfg;
   asrt_pkg::res_type res_ff [3];
   asrt_pkg::res_type res_in [3];
   asrt_pkg::res_type out_ff, out_in;

   state_type   state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [20:0] bc_ff, bc_in;
   logic [23:0] raw_ff, raw_in;
   logic [20:0] h_ff, h_in, p_ff, p_in;
   logic [19:0] put_ff, put_in, lastp_ff, lastp_in;
   logic [1:0]  mode_ff, mode_in;
   logic [5:0]  hf_ff, hf_in;
   logic [19:0] wpos_ff, wpos_in, pwp_ff, pwp_in, paused_ff, paused_in;
   logic [20:0] pend_ff, pend_in;
   logic [31:0] bst_ff, bst_in;
   logic [20:0] size_ff, size_in;
   logic [19:0] pd0_ff, pd0_in, ps0_ff, ps0_in;
   logic [20:0] d0_ff, d0_in, d1_ff, d1_in;
   logic [20:0] pos_ff, pos_in, len_ff, len_in, adj_ff, adj_in;
   logic [20:0] s0_ff, s0_in, s1_ff, s1_in, sent_ff, sent_in;
   logic [21:0] v_ff, v_in, t_ff, t_in;
   logic        ok_ff, ok_in;
   logic [1:0]  n_ff, n_in, idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic [20:0] osent_ff, osent_in;
   logic        opre_ff, opre_in;
   logic [1:0]  omode_ff, omode_in;

   logic                      mod_start, mod_busy, mod_done;
   logic [asrt_pkg::DvdW-1:0] mod_dvd;
   logic [asrt_pkg::DivW-1:0] mod_div;
   logic [asrt_pkg::RemW-1:0] mod_rem;

   asrt_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg
   );

   asrt_mod_unit u_mod (
      .clock, .reset, .start(mod_start), .dividend(mod_dvd), .divisor(mod_div),
      .busy(mod_busy), .done(mod_done), .remainder(mod_rem)
   );

   // playback position relative to base, shared by send and stop
   logic [23:0] pdiff;
   logic        pinside;
   assign pdiff   = raw_ff - cfg.play_ring_base;
   assign pinside = (raw_ff >= cfg.play_ring_base) && (pdiff <= {3'd0, p_ff});

   assign req_ready = (state_ff == ST_IDLE) && !emit_ff;
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_dest_offset   = out_ff.dest_offset;
   assign rsp_source_offset = out_ff.source_offset;
   assign rsp_length        = out_ff.length;
   assign rsp_second_offset = out_ff.second_offset;
   assign rsp_second_length = out_ff.second_length;
   assign rsp_into_header   = out_ff.into_header;
   assign rsp_sent_bytes    = osent_ff;
   assign rsp_preset_done   = opre_ff;
   assign rsp_mode_now      = omode_ff;
   assign rsp_last          = last_ff;

   function automatic asrt_pkg::res_type mk(input logic [2:0] k, input logic [20:0] d,
                                            input logic [20:0] s, input logic [20:0] l);
      asrt_pkg::res_type r;
      r               = '0;
      r.kind          = k;
      r.dest_offset   = d[19:0];
      r.source_offset = s[19:0];
      r.length        = l;
      return r;
   endfunction

   // scratch for the combinational steps
   logic [20:0] q_len, q_room, room, hr, dsum, cnt, e, mx;
   logic [21:0] lhs, rhs, w, q;
   logic [20:0] add;
   logic [21:0] psum;
   asrt_pkg::res_type seg [3];
   logic [1:0]  k;

   always_comb begin
      state_in = state_ff;  emit_in = emit_ff;
      cmd_in = cmd_ff; bc_in = bc_ff; raw_in = raw_ff;
      h_in = h_ff; p_in = p_ff; put_in = put_ff; lastp_in = lastp_ff;
      mode_in = mode_ff; hf_in = hf_ff; wpos_in = wpos_ff; pwp_in = pwp_ff;
      paused_in = paused_ff; pend_in = pend_ff; bst_in = bst_ff;
      size_in = size_ff; pd0_in = pd0_ff; ps0_in = ps0_ff;
      d0_in = d0_ff; d1_in = d1_ff; pos_in = pos_ff; len_in = len_ff;
      adj_in = adj_ff; s0_in = s0_ff; s1_in = s1_ff; sent_in = sent_ff;
      v_in = v_ff; t_in = t_ff; ok_in = ok_ff; n_in = n_ff; idx_in = idx_ff;
      res_in = res_ff; out_in = out_ff; rsp_valid_in = rsp_valid_ff;
      last_in = last_ff; osent_in = osent_ff; opre_in = opre_ff; omode_in = omode_ff;
      mod_start = 1'b0; mod_dvd = '0; mod_div = '0;
      q_len = '0; q_room = '0; room = '0; hr = '0; dsum = '0; cnt = '0;
      e = '0; mx = '0; lhs = '0; rhs = '0; w = '0; q = '0; add = '0; psum = '0;
      seg[0] = '0; seg[1] = '0; seg[2] = '0; k = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (emit_ff) begin
               // walk the result list into the output register
               if (out_free) begin
                  out_in       = res_ff[idx_ff];
                  rsp_valid_in = 1'b1;
                  last_in      = (idx_ff == n_ff - 2'd1);
                  osent_in     = sent_ff;
                  opre_in      = (bst_ff >= {11'd0, p_ff});
                  omode_in     = mode_ff;
                  idx_in       = idx_ff + 2'd1;
                  if (idx_ff == n_ff - 2'd1) emit_in = 1'b0;
               end
            end else if (req_valid) begin
               cmd_in = req_command; bc_in = req_byte_count; raw_in = req_raw_play_address;
               sent_in = '0; idx_in = '0;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            h_in = (cfg.host_ring_bytes < asrt_pkg::HostMin) ? asrt_pkg::HostMin :
                   (cfg.host_ring_bytes > asrt_pkg::RingMax) ? asrt_pkg::RingMax :
                   cfg.host_ring_bytes;
            p_in = (cfg.play_ring_bytes < asrt_pkg::PlayMin) ? asrt_pkg::PlayMin :
                   (cfg.play_ring_bytes > asrt_pkg::RingMax) ? asrt_pkg::RingMax :
                   cfg.play_ring_bytes;
            mod_start = 1'b1;
            mod_dvd   = {12'd0, wpos_ff};
            mod_div   = h_in;
            state_in  = ST_MOD_PUT;
         end
         ST_MOD_PUT: begin
            if (mod_done) begin
               put_in    = mod_rem;
               mod_start = 1'b1;
               mod_dvd   = {12'd0, pwp_ff};
               mod_div   = p_ff;
               state_in  = ST_MOD_LAST;
            end
         end
         ST_MOD_LAST: begin
            if (mod_done) begin
               lastp_in = mod_rem;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            n_in     = 2'd1;
            res_in[0] = mk(asrt_pkg::KindAck, '0, '0, '0);
            state_in = ST_IDLE;
            emit_in  = 1'b1;
            priority if (cmd_ff == asrt_pkg::CmdQuery) begin
               if (mode_ff == asrt_pkg::ModeHeader) begin
                  res_in[0] = mk(asrt_pkg::KindFree, '0, {15'd0, hf_ff},
                                 {15'd0, HdrBytes - hf_ff});
                  res_in[0].second_length = h_ff;
                  res_in[0].into_header   = 1'b1;
               end else begin
                  q_len  = (pend_ff >= h_ff) ? 21'd0 : h_ff - pend_ff;
                  q_room = h_ff - {1'b0, put_ff};
                  if (q_room >= q_len) begin
                     res_in[0] = mk(asrt_pkg::KindFree, '0, {1'b0, put_ff}, q_len);
                  end else begin
                     res_in[0] = mk(asrt_pkg::KindFree, '0, {1'b0, put_ff}, q_room);
                     res_in[0].second_length = q_len - q_room;
                  end
               end
            end else if (cmd_ff == asrt_pkg::CmdCommit) begin
               emit_in  = 1'b0;
               state_in = ST_COMMIT;
            end else if (cmd_ff == asrt_pkg::CmdSend && mode_ff == asrt_pkg::ModePreset) begin
               emit_in   = 1'b0;
               mod_start = 1'b1;
               mod_dvd   = bst_ff;
               mod_div   = p_ff;
               d0_in     = (bst_ff >= {11'd0, p_ff}) ? 21'd0 : p_ff - bst_ff[20:0];
               d1_in     = '0;
               state_in  = ST_MOD_SENT;
            end else if (cmd_ff == asrt_pkg::CmdSend && mode_ff == asrt_pkg::ModePlay) begin
               emit_in  = 1'b0;
               state_in = ST_POS;
            end else if (cmd_ff == asrt_pkg::CmdPause || cmd_ff == asrt_pkg::CmdReset) begin
               res_in[0] = mk(asrt_pkg::KindStop, '0, '0, 21'(CLEAR_BYTES));
               if (cmd_ff == asrt_pkg::CmdReset) begin
                  mode_in = asrt_pkg::ModeHeader; hf_in = '0; wpos_in = '0;
                  pend_in = '0; bst_in = '0; pwp_in = '0; paused_in = '0;
               end else begin
                  mode_in   = asrt_pkg::ModePaused;
                  paused_in = (pinside && pdiff < {3'd0, p_ff}) ? pdiff[19:0] : 20'd0;
               end
            end else if (cmd_ff == asrt_pkg::CmdResume) begin
               mode_in   = asrt_pkg::ModePlay;
               res_in[0] = mk(asrt_pkg::KindStart, {1'b0, paused_ff}, '0, p_ff & UnitMask);
            end else begin
               res_in[0] = mk(asrt_pkg::KindAck, '0, '0, '0);
            end
         end
         ST_COMMIT: begin
            if (mode_ff == asrt_pkg::ModeHeader) begin
               room    = {15'd0, HdrBytes - hf_ff};
               add     = (bc_ff < room) ? bc_ff : room;
               hf_in   = hf_ff + add[5:0];
               if (hf_in >= HdrBytes) mode_in = asrt_pkg::ModePreset;
               size_in = bc_ff - add;
            end else begin
               size_in = bc_ff;
            end
            state_in = ST_COMMIT_ADD;
         end
         ST_COMMIT_ADD: begin
            psum      = {1'b0, pend_ff} + {1'b0, size_ff};
            pend_in   = psum[21] ? asrt_pkg::PendMax : psum[20:0];
            mod_start = 1'b1;
            mod_dvd   = 32'({1'b0, put_ff} + size_ff);
            mod_div   = h_ff;
            state_in  = ST_COMMIT_MOD;
         end
         ST_COMMIT_MOD: begin
            if (mod_done) begin
               wpos_in   = mod_rem;
               n_in      = 2'd1;
               res_in[0] = mk(asrt_pkg::KindAck, '0, '0, '0);
               emit_in   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_MOD_SENT: begin
            if (mod_done) begin
               pd0_in   = mod_rem;
               state_in = ST_SRC_A;
            end
         end
         ST_POS: begin
            pos_in   = pdiff[20:0];
            ok_in    = pinside;
            state_in = ST_FREE;
         end
         ST_FREE: begin
            lhs      = {1'b0, pos_ff} + {1'b0, p_ff};
            rhs      = {2'd0, lastp_ff} + Unit22;
            v_in     = lhs - rhs;
            ok_in    = ok_ff && (lhs >= rhs);
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            w        = (v_ff >= {1'b0, p_ff}) ? v_ff - {1'b0, p_ff} : v_ff;
            len_in   = ok_ff ? (w[20:0] & UnitMask) : 21'd0;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            pd0_in = lastp_ff;
            room   = p_ff - {1'b0, lastp_ff};
            if (room >= len_ff) begin
               d0_in = len_ff; d1_in = '0;
            end else begin
               d0_in = room; d1_in = len_ff - room;
            end
            state_in = ST_SRC_A;
         end
         ST_SRC_A: begin
            cnt      = (pend_ff < h_ff) ? pend_ff : h_ff;
            t_in     = {2'd0, put_ff} + {1'b0, h_ff} - {1'b0, cnt};
            adj_in   = cnt & UnitMask;
            state_in = ST_SRC_B;
         end
         ST_SRC_B: begin
            w        = (t_ff >= {1'b0, h_ff}) ? t_ff - {1'b0, h_ff} : t_ff;
            ps0_in   = w[19:0];
            state_in = ST_SRC_C;
         end
         ST_SRC_C: begin
            hr       = h_ff - {1'b0, ps0_ff};
            s0_in    = (hr < adj_ff) ? hr : adj_ff;
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            dsum  = d0_ff + d1_ff;
            s1_in = adj_ff - s0_ff;
            if (dsum < adj_ff) begin
               if (s0_ff >= dsum) begin
                  s0_in = dsum; s1_in = '0;
               end else begin
                  s1_in = dsum - s0_ff;
               end
            end
            if ({1'b0, dsum} >= Unit22 && {1'b0, adj_ff} >= Unit22) begin
               state_in = ST_SEGS;
            end else begin
               n_in      = 2'd1;
               res_in[0] = mk(asrt_pkg::KindAck, '0, '0, '0);
               emit_in   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SEGS: begin
            e = d0_ff - s0_ff;
            priority if (s0_ff >= d0_ff) begin
               mx     = s0_ff - d0_ff;
               seg[0] = mk(asrt_pkg::KindCopy, {1'b0, pd0_ff}, {1'b0, ps0_ff}, d0_ff);
               seg[1] = mk(asrt_pkg::KindCopy, '0, {1'b0, ps0_ff} + d0_ff, mx);
               seg[2] = mk(asrt_pkg::KindCopy, mx, '0, s1_ff);
            end else if (s1_ff >= e) begin
               seg[0] = mk(asrt_pkg::KindCopy, {1'b0, pd0_ff}, {1'b0, ps0_ff}, s0_ff);
               seg[1] = mk(asrt_pkg::KindCopy, {1'b0, pd0_ff} + s0_ff, '0, e);
               seg[2] = mk(asrt_pkg::KindCopy, '0, e, s1_ff - e);
            end else begin
               seg[0] = mk(asrt_pkg::KindCopy, {1'b0, pd0_ff}, {1'b0, ps0_ff}, s0_ff);
               seg[1] = mk(asrt_pkg::KindCopy, {1'b0, pd0_ff} + s0_ff, '0, s1_ff);
               seg[2] = mk(asrt_pkg::KindCopy, '0, '0, '0);
            end
            // drop empty segments, keep order
            for (int i = 0; i < 3; i++) begin
               if (seg[i].length != 21'd0) begin
                  res_in[k] = seg[i];
                  k = k + 2'd1;
               end
            end
            n_in     = k;
            sent_in  = s0_ff + s1_ff;
            pend_in  = pend_ff - sent_in;
            bst_in   = bst_ff + {11'd0, sent_in};
            q        = {2'd0, lastp_ff} + {1'b0, sent_in};
            w        = (q >= {1'b0, p_ff}) ? q - {1'b0, p_ff} : q;
            pwp_in   = w[19:0];
            emit_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; emit_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         mode_ff <= asrt_pkg::ModeHeader; hf_ff <= '0; wpos_ff <= '0;
         pend_ff <= '0; bst_ff <= '0; pwp_ff <= '0; paused_ff <= '0;
      end else begin
         state_ff <= state_in; emit_ff <= emit_in; rsp_valid_ff <= rsp_valid_in;
         mode_ff <= mode_in; hf_ff <= hf_in; wpos_ff <= wpos_in;
         pend_ff <= pend_in; bst_ff <= bst_in; pwp_ff <= pwp_in; paused_ff <= paused_in;
      end
      cmd_ff <= cmd_in; bc_ff <= bc_in; raw_ff <= raw_in;
      h_ff <= h_in; p_ff <= p_in; put_ff <= put_in; lastp_ff <= lastp_in;
      size_ff <= size_in; pd0_ff <= pd0_in; ps0_ff <= ps0_in;
      d0_ff <= d0_in; d1_ff <= d1_in; pos_ff <= pos_in; len_ff <= len_in;
      adj_ff <= adj_in; s0_ff <= s0_in; s1_ff <= s1_in; sent_ff <= sent_in;
      v_ff <= v_in; t_ff <= t_in; ok_ff <= ok_in; n_ff <= n_in; idx_ff <= idx_in;
      res_ff <= res_in; out_ff <= out_in; last_ff <= last_in;
      osent_ff <= osent_in; opre_ff <= opre_in; omode_ff <= omode_in;
   end

`ifndef SYNTHESIS
   // remainder unit is never left running while the sequencer is idle
   a_mod_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mod_busy)
      else $error("remainder unit busy while idle");
   // copy segments are never empty
   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == asrt_pkg::KindCopy) |-> (rsp_length != 21'd0))
      else $error("empty copy segment");
   // only copy transactions report moved bytes
   a_sent_copy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != asrt_pkg::KindCopy) |-> (rsp_sent_bytes == 21'd0))
      else $error("bytes reported without copy");
   // nothing is sent during header capture
   a_hdr_total: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == asrt_pkg::ModeHeader) |-> (bst_ff == 32'd0))
      else $error("send total moved in header mode");
`endif

endmodule

[rtl/asrt_csr.sv]
// ----------------------------------------------------------------------------
// asrt_csr: configuration registers
// APB-style access to ring sizes and playback base; pready tied high.
// ----------------------------------------------------------------------------
module asrt_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output asrt_pkg::cfg_type   cfg
);

   asrt_pkg::cfg_type cfg_ff, cfg_in;
   logic wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (paddr[3:2])
            asrt_pkg::RegHost: cfg_in.host_ring_bytes = pwdata[20:0];
            asrt_pkg::RegPlay: cfg_in.play_ring_bytes = pwdata[20:0];
            asrt_pkg::RegBase: cfg_in.play_ring_base  = pwdata[23:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         asrt_pkg::RegHost: prdata = {11'd0, cfg_ff.host_ring_bytes};
         asrt_pkg::RegPlay: prdata = {11'd0, cfg_ff.play_ring_bytes};
         asrt_pkg::RegBase: prdata = {8'd0, cfg_ff.play_ring_base};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_ring_bytes <= 21'd65536;
         cfg_ff.play_ring_bytes <= 21'd16384;
         cfg_ff.play_ring_base  <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/asrt_mod_unit.sv]
// ----------------------------------------------------------------------------
// asrt_mod_unit: iterative remainder unit
// Restoring shift-subtract, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module asrt_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [asrt_pkg::DvdW-1:0]   dividend,
   input  logic [asrt_pkg::DivW-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [asrt_pkg::RemW-1:0]   remainder
);

   localparam int CntW = $clog2(asrt_pkg::DvdW + 1);

   logic [asrt_pkg::DvdW-1:0] dvd_ff, dvd_in;
   logic [asrt_pkg::DivW-1:0] div_ff, div_in;
   logic [asrt_pkg::RemW-1:0] rem_ff, rem_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [asrt_pkg::RemW:0]   shifted;

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;
   assign shifted   = {rem_ff, dvd_ff[asrt_pkg::DvdW-1]};

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = CntW'(asrt_pkg::DvdW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (shifted >= div_ff) rem_in = asrt_pkg::RemW'(shifted - div_ff);
         else                   rem_in = shifted[asrt_pkg::RemW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for audio_stream_two_ring_transfer
// Drives command transactions and APB register writes, predicts every result
// transaction in a scoreboard class and checks them in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   import asrt_pkg::*;

   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned HdrBytes   = 40;
   localparam int unsigned Unit       = 1024;
   localparam int unsigned ClearLen   = 4096;
   localparam int unsigned DrainWait  = 200;

   // one result transaction, including the per-command status fields
   typedef struct {
      bit [2:0]  kind;
      bit [19:0] dst;
      bit [19:0] src;
      bit [20:0] len;
      bit [19:0] so;
      bit [20:0] sl;
      bit        hdr;
      bit [20:0] sent;
      bit        done;
      bit [1:0]  mode;
      bit        last;
   } xfer_t;

   // -------------------------------------------------------------------------
   // Scoreboard: pointer-keeper prediction plus the queue of expected results
   // -------------------------------------------------------------------------
   class ring_scoreboard;
      int unsigned host_reg = 65536, play_reg = 16384, base_reg = 0;
      int unsigned mode = ModeHeader, hdr_fill = 0, wr_pos = 0, pending = 0;
      int unsigned total_in = 0, total_sent = 0, play_wr = 0, paused_at = 0;
      xfer_t       expected_q[$];
      xfer_t       cur[$];
      int          errors = 0;
      int          checked = 0;
      int          commands = 0;

      function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function int unsigned host_size();
         return clamp(host_reg, 1024, 1048576);
      endfunction

      function int unsigned play_size();
         return clamp(play_reg, 2048, 1048576);
      endfunction

      function void set_reg(logic [1:0] idx, int unsigned v);
         case (idx)
            RegHost: host_reg = v & 32'h1FFFFF;
            RegPlay: play_reg = v & 32'h1FFFFF;
            RegBase: base_reg = v & 32'hFFFFFF;
            default: ;
         endcase
      endfunction

      function void add(bit [2:0] k, int unsigned d, int unsigned s, int unsigned l,
                        int unsigned so, int unsigned sl, bit hdr);
         xfer_t x;
         x.kind = k; x.dst = d; x.src = s; x.len = l;
         x.so = so; x.sl = sl; x.hdr = hdr;
         cur.push_back(x);
      endfunction

      // position of raw within the playback ring, -1 when outside 0..P
      function longint ring_offset(bit [23:0] raw, int unsigned p);
         if (raw < base_reg || raw - base_reg > p) return -1;
         return raw - base_reg;
      endfunction

      // a command was accepted: work out the results it causes
      function void note_command(bit [2:0] cmd, bit [20:0] bc, bit [23:0] raw);
         int unsigned h, p, put, lastp, sent, len, pos, sz, room, take;
         int unsigned pd0, d0, pd1, d1, ps0, s0, s1, cnt, adj, diff;
         int unsigned sd[3], ss[3], sl[3];
         longint      ro;
         h = host_size();
         p = play_size();
         put = wr_pos % h;
         lastp = play_wr % p;
         sent = 0;
         cur.delete();
         commands++;
         if (cmd == CmdQuery) begin
            if (mode == ModeHeader) begin
               add(KindFree, 0, hdr_fill, HdrBytes - hdr_fill, 0, h, 1);
            end else begin
               len = pending >= h ? 0 : h - pending;
               if (h - put >= len) add(KindFree, 0, put, len, 0, 0, 0);
               else add(KindFree, 0, put, h - put, 0, len - (h - put), 0);
            end
         end else if (cmd == CmdCommit) begin
            sz = bc;
            if (mode == ModeHeader) begin
               room = HdrBytes - hdr_fill;
               take = sz < room ? sz : room;
               hdr_fill += take;
               if (hdr_fill >= HdrBytes) mode = ModePreset;
               sz -= take;
            end
            wr_pos = (put + sz) % h;
            pending = (pending + sz > PendMax) ? PendMax : pending + sz;
            total_in += sz;
            add(KindAck, 0, 0, 0, 0, 0, 0);
         end else if (cmd == CmdSend && (mode == ModePreset || mode == ModePlay)) begin
            pd1 = 0; d1 = 0;
            if (mode == ModePreset) begin
               pd0 = total_sent % p;
               d0 = total_sent >= p ? 0 : p - total_sent;
            end else begin
               len = 0;
               ro = ring_offset(raw, p);
               if (ro >= 0) begin
                  pos = ro;
                  if (pos + p >= lastp + Unit)
                     len = ((pos + p - lastp - Unit) % p) / Unit * Unit;
               end
               pd0 = lastp;
               if (p - lastp >= len) d0 = len;
               else begin
                  d0 = p - lastp;
                  d1 = len - d0;
               end
            end
            cnt = pending < h ? pending : h;
            ps0 = (put + h - cnt) % h;
            adj = cnt / Unit * Unit;
            s0 = (h - ps0 < adj) ? h - ps0 : adj;
            s1 = adj - s0;
            if (d0 + d1 >= Unit && s0 + s1 >= Unit) begin
               if (d0 + d1 < s0 + s1) begin
                  diff = (s0 + s1) - (d0 + d1);
                  if (diff >= s1) begin
                     s0 -= diff - s1;
                     s1 = 0;
                  end else s1 -= diff;
               end
               if (s0 >= d0) begin
                  sd = '{pd0, pd1, pd1 + s0 - d0};
                  ss = '{ps0, ps0 + d0, 0};
                  sl = '{d0, s0 - d0, s1};
               end else if (s1 >= d0 - s0) begin
                  sd = '{pd0, pd0 + s0, pd1};
                  ss = '{ps0, 0, d0 - s0};
                  sl = '{s0, d0 - s0, s1 - (d0 - s0)};
               end else begin
                  sd = '{pd0, pd0 + s0, 0};
                  ss = '{ps0, 0, 0};
                  sl = '{s0, s1, 0};
               end
               for (int i = 0; i < 3; i++)
                  if (sl[i] > 0) add(KindCopy, sd[i], ss[i], sl[i], 0, 0, 0);
               sent = s0 + s1;
               pending -= sent;
               total_sent += sent;
               play_wr = (lastp + sent) % p;
            end
            if (cur.size() == 0) add(KindAck, 0, 0, 0, 0, 0, 0);
         end else if (cmd == CmdPause || cmd == CmdReset) begin
            mode = ModePaused;
            ro = ring_offset(raw, p);
            paused_at = (ro < 0 || ro >= p) ? 0 : ro;
            if (cmd == CmdReset) begin
               mode = ModeHeader; hdr_fill = 0; wr_pos = 0; pending = 0;
               total_in = 0; total_sent = 0; play_wr = 0; paused_at = 0;
            end
            add(KindStop, 0, 0, ClearLen, 0, 0, 0);
         end else if (cmd == CmdResume) begin
            mode = ModePlay;
            add(KindStart, paused_at, 0, p / Unit * Unit, 0, 0, 0);
         end else begin
            // unknown command, or send while idle in header/paused mode
            add(KindAck, 0, 0, 0, 0, 0, 0);
         end
         foreach (cur[i]) begin
            cur[i].sent = sent;
            cur[i].done = total_sent >= p;
            cur[i].mode = mode;
            cur[i].last = (i == cur.size() - 1);
            expected_q.push_back(cur[i]);
         end
      endfunction

      function void cmp(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            $error("rsp_%s: expected %0d, got %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(xfer_t a);
         xfer_t e;
         checked++;
         if (expected_q.size() == 0) begin
            $error("result transaction with nothing expected (kind %0d)", a.kind);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         cmp("kind", e.kind, a.kind);
         cmp("dest_offset", e.dst, a.dst);
         cmp("source_offset", e.src, a.src);
         cmp("length", e.len, a.len);
         cmp("second_offset", e.so, a.so);
         cmp("second_length", e.sl, a.sl);
         cmp("into_header", e.hdr, a.hdr);
         cmp("sent_bytes", e.sent, a.sent);
         cmp("preset_done", e.done, a.done);
         cmp("mode_now", e.mode, a.mode);
         cmp("last", e.last, a.last);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = '0;
   logic [20:0] req_byte_count = '0;
   logic [23:0] req_raw_play_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [19:0] rsp_dest_offset, rsp_source_offset, rsp_second_offset;
   logic [20:0] rsp_length, rsp_second_length, rsp_sent_bytes;
   logic        rsp_into_header, rsp_preset_done, rsp_last;
   logic [1:0]  rsp_mode_now;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   audio_stream_two_ring_transfer i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_command, .req_byte_count, .req_raw_play_address,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_dest_offset, .rsp_source_offset,
      .rsp_length, .rsp_second_offset, .rsp_second_length, .rsp_into_header,
      .rsp_sent_bytes, .rsp_preset_done, .rsp_mode_now, .rsp_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   ring_scoreboard sb = new();

   bit          quiet = 1'b0;      // final stretch: no idling on either side
   bit          hold_req = 1'b0;   // asks the receiver for one long hold-off
   int unsigned cycles = 0;

   // clock and run limit
   initial begin
      forever begin
         #5 clock = ~clock;
         if (clock) begin
            cycles++;
            if (cycles > CycleLimit) begin
               $display("tb: errors");
               $finish;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: checks each accepted result, then picks next rsp_ready.
   // Outputs are sampled right after the edge, before the DUT's updates land.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      xfer_t       got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.kind = rsp_kind; got.dst = rsp_dest_offset; got.src = rsp_source_offset;
            got.len = rsp_length; got.so = rsp_second_offset;
            got.sl = rsp_second_length; got.hdr = rsp_into_header;
            got.sent = rsp_sent_bytes; got.done = rsp_preset_done;
            got.mode = rsp_mode_now; got.last = rsp_last;
            sb.check_result(got);
         end
         if (hold_req) begin
            // long hold-off so the block backs up and stalls req_ready
            hold_req = 1'b0;
            stall_left = 600;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // offer one command; returns at the edge that accepted it, or after a random idle gap
   task automatic issue(bit [2:0] cmd, bit [20:0] bc, bit [23:0] raw);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_byte_count <= bc;
      req_raw_play_address <= raw;
      do @(posedge clock); while (!req_ready);
      sb.note_command(cmd, bc, raw);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // sender goes idle until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // APB write followed by a readback of the same register
   task automatic csr_write(logic [1:0] idx, int unsigned v);
      int unsigned mask;
      mask = (idx == RegBase) ? 32'hFFFFFF : 32'h1FFFFF;
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, v);
      pwrite <= 1'b0; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if ((prdata & mask) != (v & mask)) begin
         $error("register %0d readback: expected %0d, got %0d", idx, v & mask, prdata & mask);
         sb.errors++;
      end
      psel <= 1'b0; penable <= 1'b0;
      @(posedge clock);
   endtask

   // raw position: mostly inside the ring, sometimes anywhere
   function automatic bit [23:0] pick_raw();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 24'hFFFFFF);
      return sb.base_reg + $urandom_range(0, sb.play_size());
   endfunction

   // random mix weighted toward commit/send streams so playback gets deep
   task automatic random_run(int n);
      int unsigned r;
      bit [20:0]   bc;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (n > 40 && i == n / 2 && !quiet) hold_req = 1'b1;
         if (r < 40) begin
            bc = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                              : $urandom_range(0, 6000);
            issue(CmdCommit, bc, $urandom_range(0, 24'hFFFFFF));
         end else if (r < 75) issue(CmdSend, 0, pick_raw());
         else if (r < 82) issue(CmdQuery, 0, 0);
         else if (r < 88) issue(CmdPause, 0, pick_raw());
         else if (r < 96) issue(CmdResume, 0, 0);
         else if (r < 98) issue(CmdReset, 0, pick_raw());
         else issue($urandom_range(6, 7), $urandom_range(0, 21'h1FFFFF),
                    $urandom_range(0, 24'hFFFFFF));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: header capture, preset fill, playing, pause/resume, corners
      issue(CmdQuery, 0, 0);                     // header store, whole ring
      issue(CmdSend, 0, 0);                      // send in header mode: ack
      issue(CmdCommit, 10, 0);                   // partial header
      issue(CmdQuery, 0, 0);
      issue(CmdCommit, 100, 0);                  // header full, 70 pending
      issue(CmdSend, 0, 0);                      // under one unit: ack
      issue(CmdCommit, 9000, 0);
      issue(CmdQuery, 0, 0);
      issue(CmdSend, 0, 0);                      // preset copy
      issue(CmdCommit, 20000, 0);
      issue(CmdSend, 0, 0);                      // finishes preset
      issue(CmdResume, 0, 0);
      issue(CmdSend, 0, 24'd12000);              // playing, inside ring
      issue(CmdSend, 0, 24'hFFFFFF);             // outside ring: no space
      issue(CmdPause, 0, 24'hFFFFFF);            // outside: saved as 0
      issue(CmdSend, 0, 0);                      // paused: ack
      issue(CmdPause, 0, 24'd5000);
      issue(CmdResume, 0, 0);
      issue(3'd6, 21'h1FFFFF, 24'hFFFFFF);       // unknown command
      issue(3'd7, 0, 0);
      issue(CmdCommit, 21'h1FFFFF, 0);           // pending saturates
      issue(CmdCommit, 21'h1FFFFF, 0);
      issue(CmdQuery, 0, 0);                     // ring full
      issue(CmdSend, 0, 24'd16384);              // position at ring end
      issue(CmdReset, 0, 24'd100);
      drain();

      random_run(60);
      drain();

      // smallest rings, high base
      csr_write(RegHost, 1024);
      csr_write(RegPlay, 2048);
      csr_write(RegBase, 24'hFFF000);
      random_run(60);
      drain();

      // largest rings
      csr_write(RegHost, 1048576);
      csr_write(RegPlay, 1048576);
      csr_write(RegBase, 0);
      random_run(60);
      drain();

      // out-of-range sizes get saturated; stale pointers get reduced
      csr_write(RegHost, 0);
      csr_write(RegPlay, 21'h1FFFFF);
      csr_write(RegBase, 24'hFFFFFF);
      random_run(50);
      drain();

      // odd sizes, no idling from here on
      csr_write(RegHost, 3000);
      csr_write(RegPlay, 5000);
      csr_write(RegBase, 12345);
      quiet = 1'b1;
      random_run(50);
      drain();

      $display("tb: %0d commands and %0d results over five ring settings",
               sb.commands, sb.checked);
      $display("tb: covered header, preset, playing, pause, resume and reset");
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/asrt_pkg.sv
rtl/asrt_csr.sv
rtl/asrt_mod_unit.sv
rtl/audio_stream_two_ring_transfer.sv
tb/tb.sv
